// File: rtl/spk_rle_pkg.sv
// Package for the SPK run-length image decoder.
// Holds the transfer payload types and the fixed format constants.
// No dependencies.
package spk_rle_pkg;

   // Width of the configuration registers and of the run length field.
   localparam int CSR_W = 13;
   localparam int RUN_W = 17;
   localparam int OFFSET_W = 24;

   // Configuration register indexes.
   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   // Reset values of the image size registers.
   localparam logic [CSR_W-1:0] IMAGE_WIDTH_RESET  = 13'd320;
   localparam logic [CSR_W-1:0] IMAGE_HEIGHT_RESET = 13'd200;

   // Flag words of the compressed format.
   localparam logic [15:0] FLAG_ZERO_RUN = 16'hFFFF;
   localparam logic [15:0] FLAG_LITERAL  = 16'hFFFE;

   // One byte of the compressed file.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_file;
   } req_type;

   // One run descriptor.
   typedef struct packed {
      logic [OFFSET_W-1:0] pixel_offset;
      logic [RUN_W-1:0]    run_length;
      logic [7:0]          pixel_value;
      logic                image_full;
   } rsp_type;

endpackage

// File: rtl/spk_rle_image_decoder.sv
// SPK run-length image decoder: parses the compressed byte stream and
// emits run descriptors. Depends on spk_rle_pkg.
// A run descriptor's byte is held in the input byte register, and the descriptor
// is then registered in the result register as soon as that register is free.
// Throughput: one byte per cycle; a stalled result holds the parse step and
// then stalls the input. Synchronous reset clears the parser, the write
// position, the handshake state and sets the image size to 320 by 200.
module spk_rle_image_decoder
   import spk_rle_pkg::*;
#(
   parameter int MAX_SIDE = 4096
) (
   input  logic             clock,
   input  logic             reset,
   // Compressed byte input
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   // Run descriptor output
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   // Configuration writes
   input  logic             csr_write,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
   localparam int TOTAL_W = 2 * SIDE_W;
   localparam int WIDE_W  = (TOTAL_W > RUN_W) ? TOTAL_W : RUN_W;

   typedef enum logic [2:0] {
      PH_FLAG_LO,
      PH_FLAG_HI,
      PH_COUNT_LO,
      PH_COUNT_HI,
      PH_LITERAL
   } phase_type;

   // Registers
   logic [CSR_W-1:0]   width_ff, width_in;
   logic [CSR_W-1:0]   height_ff, height_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               in_valid_ff, in_valid_in;
   req_type            in_data_ff, in_data_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   phase_type          phase_ff, phase_in;
   logic [7:0]         flag_low_ff, flag_low_in;
   logic               zero_run_ff, zero_run_in;
   logic [7:0]         count_low_ff, count_low_in;
   logic [RUN_W-1:0]   lit_left_ff, lit_left_in;
   logic [TOTAL_W-1:0] wpos_ff, wpos_in;
   logic               done_ff, done_in;

   // Combinational helpers
   logic [SIDE_W-1:0]  width_side;
   logic [SIDE_W-1:0]  height_side;
   logic               fire;
   logic               req_accept;
   phase_type          phase_eff;
   logic [7:0]         flag_low_eff;
   logic               zero_run_eff;
   logic [7:0]         count_low_eff;
   logic [RUN_W-1:0]   lit_left_eff;
   logic [TOTAL_W-1:0] wpos_eff;
   logic               done_eff;
   logic [15:0]        flag_word;
   logic [RUN_W-1:0]   count_pixels;
   logic               emit;
   logic [RUN_W-1:0]   emit_len;
   logic [7:0]         emit_value;
   logic [WIDE_W-1:0]  room;
   logic [WIDE_W-1:0]  len_wide;
   logic               reach_end;
   logic [RUN_W-1:0]   run_n;

   // Clamp a configured side to the range one to MAX_SIDE.
   function automatic logic [SIDE_W-1:0] clamp_side(input logic [CSR_W-1:0] v);
      logic [SIDE_W-1:0] r;
      if (v == '0) begin
         r = SIDE_W'(1);
      end else if (v > CSR_W'(MAX_SIDE)) begin
         r = SIDE_W'(MAX_SIDE);
      end else begin
         r = SIDE_W'(v);
      end
      return r;
   endfunction

   // Image size registers and the registered pixel total.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata;
            CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
      width_side  = clamp_side(width_ff);
      height_side = clamp_side(height_ff);
      total_in    = TOTAL_W'(width_side) * TOTAL_W'(height_side);
   end

   // Handshake: the parse step fires when the result register can take a value.
   assign fire       = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !fire;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   // Parse step: start of file clears the parser, then one byte is consumed.
   always_comb begin
      if (in_data_ff.start_of_file) begin
         phase_eff     = PH_FLAG_LO;
         flag_low_eff  = '0;
         zero_run_eff  = 1'b0;
         count_low_eff = '0;
         lit_left_eff  = '0;
         wpos_eff      = '0;
         done_eff      = 1'b0;
      end else begin
         phase_eff     = phase_ff;
         flag_low_eff  = flag_low_ff;
         zero_run_eff  = zero_run_ff;
         count_low_eff = count_low_ff;
         lit_left_eff  = lit_left_ff;
         wpos_eff      = wpos_ff;
         done_eff      = done_ff;
      end
      // A size change can leave the position at or past the new end.
      done_eff = done_eff || (wpos_eff >= total_ff);

      flag_word    = {in_data_ff.data_byte, flag_low_eff};
      count_pixels = {in_data_ff.data_byte, count_low_eff, 1'b0};

      phase_in     = phase_eff;
      flag_low_in  = flag_low_eff;
      zero_run_in  = zero_run_eff;
      count_low_in = count_low_eff;
      lit_left_in  = lit_left_eff;
      emit         = 1'b0;
      emit_len     = count_pixels;
      emit_value   = '0;

      if (!done_eff) begin
         case (phase_eff)
            PH_FLAG_LO: begin
               flag_low_in = in_data_ff.data_byte;
               phase_in    = PH_FLAG_HI;
            end
            PH_FLAG_HI: begin
               zero_run_in = (flag_word == FLAG_ZERO_RUN);
               if (flag_word == FLAG_ZERO_RUN || flag_word == FLAG_LITERAL) begin
                  phase_in = PH_COUNT_LO;
               end else begin
                  phase_in = PH_FLAG_LO;
               end
            end
            PH_COUNT_LO: begin
               count_low_in = in_data_ff.data_byte;
               phase_in     = PH_COUNT_HI;
            end
            PH_COUNT_HI: begin
               if (zero_run_eff) begin
                  // A zero count gives an empty run and no result.
                  emit     = (count_pixels != '0);
                  phase_in = PH_FLAG_LO;
               end else begin
                  lit_left_in = count_pixels;
                  phase_in    = (count_pixels != '0) ? PH_LITERAL : PH_FLAG_LO;
               end
            end
            PH_LITERAL: begin
               emit        = 1'b1;
               emit_len    = RUN_W'(1);
               emit_value  = in_data_ff.data_byte;
               lit_left_in = lit_left_eff - RUN_W'(1);
               if (lit_left_in == '0) begin
                  phase_in = PH_FLAG_LO;
               end
            end
            default: begin
               phase_in = PH_FLAG_LO;
            end
         endcase
      end

      // Clip the run at the last pixel of the image.
      room      = WIDE_W'(total_ff - wpos_eff);
      len_wide  = WIDE_W'(emit_len);
      reach_end = (len_wide >= room);
      run_n     = reach_end ? RUN_W'(room) : emit_len;

      wpos_in = wpos_eff;
      done_in = done_eff;
      if (emit) begin
         wpos_in = wpos_eff + TOTAL_W'(run_n);
         done_in = reach_end;
      end

      rsp_data_in.pixel_offset = OFFSET_W'(wpos_eff);
      rsp_data_in.run_length   = run_n;
      rsp_data_in.pixel_value  = emit_value;
      rsp_data_in.image_full   = reach_end;
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire && emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      total_ff   <= total_in;
      in_data_ff <= in_data_in;
      if (fire && emit) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (reset) begin
         width_ff     <= IMAGE_WIDTH_RESET;
         height_ff    <= IMAGE_HEIGHT_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_FLAG_LO;
         flag_low_ff  <= '0;
         zero_run_ff  <= 1'b0;
         count_low_ff <= '0;
         lit_left_ff  <= '0;
         wpos_ff      <= '0;
         done_ff      <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            phase_ff     <= phase_in;
            flag_low_ff  <= flag_low_in;
            zero_run_ff  <= zero_run_in;
            count_low_ff <= count_low_in;
            lit_left_ff  <= lit_left_in;
            wpos_ff      <= wpos_in;
            done_ff      <= done_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
